[src/bpc_pkg.sv]
// Package: item layouts and codes shared by the buffer pool frame table.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

    typedef enum logic [2:0] {
        REQ_READ    = 3'd0,
        REQ_ALLOC   = 3'd1,
        REQ_UNPIN   = 3'd2,
        REQ_DISPOSE = 3'd3,
        REQ_FLUSH   = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        KIND_STATUS    = 2'd0,
        KIND_WRITEBACK = 2'd1,
        KIND_FILL      = 2'd2,
        KIND_DISPOSE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_NOT_PINNED = 3'd3,
        ST_PINNED     = 3'd4,
        ST_BAD_FRAME  = 3'd5,
        ST_TABLE_ERR  = 3'd6
    } status_t;

    localparam int IN_FILE_W  = 8;
    localparam int IN_PAGE_W  = 20;
    localparam int OUT_FRAME_W = 5;
    localparam logic [7:0] PIN_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0]           req_type;
        logic [IN_FILE_W-1:0] file_id;
        logic [IN_PAGE_W-1:0] page_no;
        logic                 mark_dirty;
    } req_item_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [OUT_FRAME_W-1:0] frame;
        logic [IN_FILE_W-1:0]   out_file;
        logic [IN_PAGE_W-1:0]   out_page;
        logic [2:0]             status;
        logic                   last;
    } rsp_item_t;

endpackage
`default_nettype wire

[src/bpc_chan_if.sv]
// Interface: valid/ready channel carrying one item.
`timescale 1ns / 1ps
`default_nettype none
interface bpc_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/buffer_pool_clock_replacement_top.sv]
// Top level: frame table of a page buffer pool with clock replacement.
//
//  channel  dir  payload                                         handshake
//  req_ch   in   req_type file_id page_no mark_dirty             valid/ready
//  rsp_ch   out  kind frame out_file out_page status last        valid/ready
//
// One request is taken at a time. A lookup walks the frames one per cycle;
// the clock sweep moves the hand one frame a cycle, and a flush walks the
// frames in index order until it ends or stops at a pinned or bad frame.
// rst_n clears the state, hand and output valid and the per-frame flags and file ids at once.
// A stalled rsp_ch holds the sequencer before each result; req_ch stays
// low on ready until the final status item has been loaded.
`timescale 1ns / 1ps
`default_nettype none
module buffer_pool_clock_replacement_top
    import bpc_pkg::*;
#(
    parameter int NUM_FRAMES   = 32,
    parameter int FILE_ID_BITS = 8,
    parameter int PAGE_NO_BITS = 20
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bpc_chan_if.sink   req_ch,
    bpc_chan_if.source rsp_ch
);

    localparam int FB = $clog2(NUM_FRAMES);
    localparam logic [FB-1:0] LAST_IDX = FB'(NUM_FRAMES - 1);

    typedef logic [FB-1:0]           idx_t;
    typedef logic [FILE_ID_BITS-1:0] file_t;
    typedef logic [PAGE_NO_BITS-1:0] page_t;

    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_SWEEP, S_VICT, S_FILL, S_DISP, S_FLUSH, S_FINAL
    } state_t;

    // Frame table: flags and file ids reset, page numbers written on install.
    logic       valid_reg [NUM_FRAMES];
    file_t      file_reg  [NUM_FRAMES];
    page_t      page_reg  [NUM_FRAMES];
    logic [7:0] pin_reg   [NUM_FRAMES];
    logic       dirty_reg [NUM_FRAMES];
    logic       ref_reg   [NUM_FRAMES];

    state_t     state_reg;
    logic [2:0] rq_reg;
    file_t      rfile_reg;
    page_t      rpage_reg;
    logic       md_reg;
    idx_t       idx_reg;
    idx_t       hand_reg;
    idx_t       start_reg;
    logic       seen_reg;
    idx_t       vict_reg;
    idx_t       fr_reg;
    logic [2:0] st_reg;
    logic       ov_reg;
    rsp_item_t  od_reg;

    idx_t hand_next;
    logic can_emit;
    logic cur_match;
    logic cur_fmatch;

    assign hand_next  = (hand_reg == LAST_IDX) ? '0 : idx_t'(hand_reg + 1'b1);
    assign can_emit   = !ov_reg || rsp_ch.ready;
    assign cur_fmatch = (file_reg[idx_reg] == rfile_reg);
    assign cur_match  = valid_reg[idx_reg] && cur_fmatch
                        && (page_reg[idx_reg] == rpage_reg);

    assign req_ch.ready = (state_reg == S_IDLE);
    assign rsp_ch.valid = ov_reg;
    assign rsp_ch.data  = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hand_reg  <= LAST_IDX;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                file_reg[i]  <= '0;
                pin_reg[i]   <= '0;
                dirty_reg[i] <= 1'b0;
                ref_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            // Drop the output item once taken; an emission below overrides.
            if (rsp_ch.ready)
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_ch.valid)
                    begin
                        rq_reg    <= req_ch.data.req_type;
                        rfile_reg <= file_t'(req_ch.data.file_id);
                        rpage_reg <= page_t'(req_ch.data.page_no);
                        md_reg    <= req_ch.data.mark_dirty;
                        idx_reg   <= '0;
                        start_reg <= hand_reg;
                        seen_reg  <= 1'b0;
                        st_reg    <= ST_OK;
                        fr_reg    <= '0;
                        priority case (req_ch.data.req_type)
                            REQ_READ, REQ_UNPIN, REQ_DISPOSE: state_reg <= S_FIND;
                            REQ_ALLOC:                        state_reg <= S_SWEEP;
                            REQ_FLUSH:                        state_reg <= S_FLUSH;
                            default:                          state_reg <= S_FINAL;
                        endcase
                    end
                end

                S_FIND:
                begin
                    if (cur_match || idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_FINAL;
                        priority case (rq_reg)
                            REQ_READ:
                            begin
                                if (cur_match)
                                begin
                                    ref_reg[idx_reg] <= 1'b1;
                                    if (pin_reg[idx_reg] != PIN_MAX)
                                        pin_reg[idx_reg] <= pin_reg[idx_reg] + 8'd1;
                                    fr_reg <= idx_reg;
                                end
                                else
                                begin
                                    start_reg <= hand_reg;
                                    seen_reg  <= 1'b0;
                                    state_reg <= S_SWEEP;
                                end
                            end
                            REQ_ALLOC:
                            begin
                                // Lookup after the sweep: a copy elsewhere is a table error.
                                fr_reg <= vict_reg;
                                if (cur_match && idx_reg != vict_reg)
                                begin
                                    valid_reg[vict_reg] <= 1'b0;
                                    file_reg[vict_reg]  <= '0;
                                    pin_reg[vict_reg]   <= '0;
                                    dirty_reg[vict_reg] <= 1'b0;
                                    ref_reg[vict_reg]   <= 1'b0;
                                    st_reg              <= ST_TABLE_ERR;
                                end
                                else
                                begin
                                    valid_reg[vict_reg] <= 1'b1;
                                    file_reg[vict_reg]  <= rfile_reg;
                                    page_reg[vict_reg]  <= rpage_reg;
                                    pin_reg[vict_reg]   <= 8'd1;
                                    dirty_reg[vict_reg] <= 1'b0;
                                    ref_reg[vict_reg]   <= 1'b1;
                                end
                            end
                            REQ_UNPIN:
                            begin
                                if (!cur_match)
                                    st_reg <= ST_NOT_FOUND;
                                else
                                begin
                                    fr_reg <= idx_reg;
                                    if (pin_reg[idx_reg] == 8'd0)
                                        st_reg <= ST_NOT_PINNED;
                                    else
                                    begin
                                        pin_reg[idx_reg] <= pin_reg[idx_reg] - 8'd1;
                                        if (md_reg)
                                            dirty_reg[idx_reg] <= 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                // Dispose: free the frame even if pinned.
                                if (cur_match)
                                begin
                                    fr_reg             <= idx_reg;
                                    valid_reg[idx_reg] <= 1'b0;
                                    file_reg[idx_reg]  <= '0;
                                    pin_reg[idx_reg]   <= '0;
                                    dirty_reg[idx_reg] <= 1'b0;
                                    ref_reg[idx_reg]   <= 1'b0;
                                end
                                state_reg <= S_DISP;
                            end
                        endcase
                    end
                    else
                        idx_reg <= idx_t'(idx_reg + 1'b1);
                end

                S_SWEEP:
                begin
                    // Advance the hand one frame; clear reference, skip pinned.
                    hand_reg <= hand_next;
                    if (ref_reg[hand_next])
                        ref_reg[hand_next] <= 1'b0;
                    else if (pin_reg[hand_next] != 8'd0)
                    begin
                        if (hand_next == start_reg)
                        begin
                            if (seen_reg)
                            begin
                                st_reg    <= ST_FULL;
                                fr_reg    <= '0;
                                state_reg <= S_FINAL;
                            end
                            else
                                seen_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        vict_reg  <= hand_next;
                        state_reg <= S_VICT;
                    end
                end

                S_VICT:
                begin
                    if (dirty_reg[vict_reg])
                    begin
                        if (can_emit)
                        begin
                            ov_reg              <= 1'b1;
                            od_reg.kind         <= KIND_WRITEBACK;
                            od_reg.frame        <= OUT_FRAME_W'(vict_reg);
                            od_reg.out_file     <= IN_FILE_W'(file_reg[vict_reg]);
                            od_reg.out_page     <= IN_PAGE_W'(page_reg[vict_reg]);
                            od_reg.status       <= ST_OK;
                            od_reg.last         <= 1'b0;
                            dirty_reg[vict_reg] <= 1'b0;
                        end
                    end
                    else if (rq_reg == REQ_ALLOC)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_FIND;
                    end
                    else
                        state_reg <= S_FILL;
                end

                S_FILL:
                begin
                    if (can_emit)
                    begin
                        ov_reg              <= 1'b1;
                        od_reg.kind         <= KIND_FILL;
                        od_reg.frame        <= OUT_FRAME_W'(vict_reg);
                        od_reg.out_file     <= IN_FILE_W'(rfile_reg);
                        od_reg.out_page     <= IN_PAGE_W'(rpage_reg);
                        od_reg.status       <= ST_OK;
                        od_reg.last         <= 1'b0;
                        valid_reg[vict_reg] <= 1'b1;
                        file_reg[vict_reg]  <= rfile_reg;
                        page_reg[vict_reg]  <= rpage_reg;
                        pin_reg[vict_reg]   <= 8'd1;
                        dirty_reg[vict_reg] <= 1'b0;
                        ref_reg[vict_reg]   <= 1'b1;
                        fr_reg              <= vict_reg;
                        state_reg           <= S_FINAL;
                    end
                end

                S_DISP:
                begin
                    if (can_emit)
                    begin
                        ov_reg          <= 1'b1;
                        od_reg.kind     <= KIND_DISPOSE;
                        od_reg.frame    <= OUT_FRAME_W'(fr_reg);
                        od_reg.out_file <= IN_FILE_W'(rfile_reg);
                        od_reg.out_page <= IN_PAGE_W'(rpage_reg);
                        od_reg.status   <= ST_OK;
                        od_reg.last     <= 1'b0;
                        state_reg       <= S_FINAL;
                    end
                end

                S_FLUSH:
                begin
                    if (valid_reg[idx_reg] && cur_fmatch)
                    begin
                        if (pin_reg[idx_reg] != 8'd0)
                        begin
                            st_reg    <= ST_PINNED;
                            fr_reg    <= idx_reg;
                            state_reg <= S_FINAL;
                        end
                        else if (!dirty_reg[idx_reg] || can_emit)
                        begin
                            if (dirty_reg[idx_reg])
                            begin
                                ov_reg          <= 1'b1;
                                od_reg.kind     <= KIND_WRITEBACK;
                                od_reg.frame    <= OUT_FRAME_W'(idx_reg);
                                od_reg.out_file <= IN_FILE_W'(file_reg[idx_reg]);
                                od_reg.out_page <= IN_PAGE_W'(page_reg[idx_reg]);
                                od_reg.status   <= ST_OK;
                                od_reg.last     <= 1'b0;
                            end
                            valid_reg[idx_reg] <= 1'b0;
                            file_reg[idx_reg]  <= '0;
                            pin_reg[idx_reg]   <= '0;
                            dirty_reg[idx_reg] <= 1'b0;
                            ref_reg[idx_reg]   <= 1'b0;
                            if (idx_reg == LAST_IDX)
                                state_reg <= S_FINAL;
                            else
                                idx_reg <= idx_t'(idx_reg + 1'b1);
                        end
                    end
                    else if (!valid_reg[idx_reg] && rfile_reg != '0 && cur_fmatch)
                    begin
                        st_reg    <= ST_BAD_FRAME;
                        fr_reg    <= idx_reg;
                        state_reg <= S_FINAL;
                    end
                    else if (idx_reg == LAST_IDX)
                        state_reg <= S_FINAL;
                    else
                        idx_reg <= idx_t'(idx_reg + 1'b1);
                end

                S_FINAL:
                begin
                    if (can_emit)
                    begin
                        ov_reg          <= 1'b1;
                        od_reg.kind     <= KIND_STATUS;
                        od_reg.frame    <= OUT_FRAME_W'(fr_reg);
                        od_reg.out_file <= IN_FILE_W'(rfile_reg);
                        od_reg.out_page <= IN_PAGE_W'(rpage_reg);
                        od_reg.status   <= st_reg;
                        od_reg.last     <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[src/bpc_checker.sv]
// Checker: port-level assertions for the frame table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bpc_checker
    import bpc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire rsp_item_t out_data
);

    // Hold a stalled result unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // No new request while a non-final result item of the current run waits.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !in_ready)
        else $error("ready while a run is in progress");

    // A taken request keeps the block busy in the next cycle.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready straight after a request");

    // Non-final result items carry status ok; a full pool grants no frame.
    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last || out_data.status == ST_OK)
                      && (out_data.status != ST_FULL || out_data.frame == '0))
        else $error("bad status or frame on result");

endmodule

bind buffer_pool_clock_replacement_top bpc_checker u_bpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req_ch.valid),
    .in_ready  (req_ch.ready),
    .out_valid (rsp_ch.valid),
    .out_ready (rsp_ch.ready),
    .out_data  (rsp_ch.data)
);
`default_nettype wire

[test/bpc_frame_checker.sv]
// Checker: predicts frame-table results from request items and compares them.
`timescale 1ns / 1ps
module bpc_frame_checker
    import bpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_fire,
    input  req_item_t req_item,
    input  logic      rsp_fire,
    input  rsp_item_t rsp_item,
    output int        errors,
    output int        pending,
    output int        rsp_count
);
    localparam int NF = 32;

    logic        f_valid [NF];
    logic [7:0]  f_file  [NF];
    logic [19:0] f_page  [NF];
    logic [7:0]  f_pins  [NF];
    logic        f_dirty [NF];
    logic        f_ref   [NF];
    logic [4:0]  hand;
    rsp_item_t   expected_q[$];

    task automatic report(input string what, input rsp_item_t got, input rsp_item_t want);
        $display("checker: %s got k%0d f%0d file%0d pg%0d st%0d l%0d",
                 what, got.kind, got.frame, got.out_file, got.out_page, got.status,
                 got.last);
        $display("checker:   want k%0d f%0d file%0d pg%0d st%0d l%0d",
                 want.kind, want.frame, want.out_file, want.out_page, want.status,
                 want.last);
        errors++;
    endtask

    function automatic void push(input kind_t k, input int fr, input logic [7:0] fl,
                                 input logic [19:0] pg, input status_t st, input logic l);
        rsp_item_t r;
        r.kind = k; r.frame = fr[4:0]; r.out_file = fl; r.out_page = pg;
        r.status = st; r.last = l;
        expected_q.push_back(r);
    endfunction

    function automatic int lookup(input logic [7:0] fl, input logic [19:0] pg);
        for (int i = 0; i < NF; i++)
            if (f_valid[i] && f_file[i] == fl && f_page[i] == pg)
                return i;
        return -1;
    endfunction

    function automatic void clear_frame(input int f);
        f_valid[f] = 0; f_file[f] = 0; f_page[f] = 0;
        f_pins[f] = 0; f_dirty[f] = 0; f_ref[f] = 0;
    endfunction

    // advance the hand; -1 when every frame stays pinned
    function automatic int clock_victim();
        logic [4:0] start;
        bit seen;
        start = hand;
        seen = 0;
        for (int g = 0; g < 4 * NF + 4; g++) begin
            hand = hand + 5'd1;
            if (f_ref[hand]) begin
                f_ref[hand] = 0;
                continue;
            end
            if (f_pins[hand] != 0) begin
                if (hand == start) begin
                    if (seen)
                        return -1;
                    seen = 1;
                end
                continue;
            end
            return hand;
        end
        return -1;
    endfunction

    function automatic void predict_frames(input req_item_t q);
        int h, v;
        logic [7:0] fl;
        logic [19:0] pg;
        fl = q.file_id;
        pg = q.page_no;
        case (q.req_type)
            REQ_READ, REQ_ALLOC: begin
                if (q.req_type == REQ_READ) begin
                    h = lookup(fl, pg);
                    if (h >= 0) begin
                        f_ref[h] = 1;
                        if (f_pins[h] != PIN_MAX)
                            f_pins[h]++;
                        push(KIND_STATUS, h, fl, pg, ST_OK, 1);
                        return;
                    end
                end
                v = clock_victim();
                if (v < 0) begin
                    push(KIND_STATUS, 0, fl, pg, ST_FULL, 1);
                    return;
                end
                if (f_dirty[v]) begin
                    push(KIND_WRITEBACK, v, f_file[v], f_page[v], ST_OK, 0);
                    f_dirty[v] = 0;
                end
                if (q.req_type == REQ_ALLOC) begin
                    h = lookup(fl, pg);
                    if (h >= 0 && h != v) begin
                        clear_frame(v);
                        push(KIND_STATUS, v, fl, pg, ST_TABLE_ERR, 1);
                        return;
                    end
                end else
                    push(KIND_FILL, v, fl, pg, ST_OK, 0);
                f_valid[v] = 1; f_file[v] = fl; f_page[v] = pg;
                f_pins[v] = 1; f_dirty[v] = 0; f_ref[v] = 1;
                push(KIND_STATUS, v, fl, pg, ST_OK, 1);
            end
            REQ_UNPIN: begin
                h = lookup(fl, pg);
                if (h < 0)
                    push(KIND_STATUS, 0, fl, pg, ST_NOT_FOUND, 1);
                else if (f_pins[h] == 0)
                    push(KIND_STATUS, h, fl, pg, ST_NOT_PINNED, 1);
                else begin
                    f_pins[h]--;
                    if (q.mark_dirty)
                        f_dirty[h] = 1;
                    push(KIND_STATUS, h, fl, pg, ST_OK, 1);
                end
            end
            REQ_DISPOSE: begin
                h = lookup(fl, pg);
                v = 0;
                if (h >= 0) begin
                    v = h;
                    clear_frame(v);
                end
                push(KIND_DISPOSE, v, fl, pg, ST_OK, 0);
                push(KIND_STATUS, v, fl, pg, ST_OK, 1);
            end
            REQ_FLUSH: begin
                for (int i = 0; i < NF; i++) begin
                    if (f_valid[i] && f_file[i] == fl) begin
                        if (f_pins[i] != 0) begin
                            push(KIND_STATUS, i, fl, pg, ST_PINNED, 1);
                            return;
                        end
                        if (f_dirty[i])
                            push(KIND_WRITEBACK, i, f_file[i], f_page[i], ST_OK, 0);
                        clear_frame(i);
                    end else if (!f_valid[i] && fl != 0 && f_file[i] == fl) begin
                        push(KIND_STATUS, i, fl, pg, ST_BAD_FRAME, 1);
                        return;
                    end
                end
                push(KIND_STATUS, 0, fl, pg, ST_OK, 1);
            end
            default: push(KIND_STATUS, 0, fl, pg, ST_OK, 1);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_item_t want;
        if (!rst_n) begin
            for (int i = 0; i < NF; i++)
                clear_frame(i);
            hand = 5'(NF - 1);
            expected_q.delete();
            errors = 0;
            rsp_count = 0;
            pending = 0;
        end else begin
            // results are matched before the new request is predicted
            if (rsp_fire) begin
                rsp_count++;
                if (expected_q.size() == 0)
                    report("unexpected", rsp_item, rsp_item);
                else begin
                    want = expected_q.pop_front();
                    if (rsp_item !== want)
                        report("mismatch", rsp_item, want);
                end
            end
            if (req_fire)
                predict_frames(req_item);
            pending = expected_q.size();
        end
    end
endmodule

[test/tb_buffer_pool_clock_replacement_top.sv]
// Testbench top: drives requests to the frame table and gives the verdict.
`timescale 1ns / 1ps
module tb_buffer_pool_clock_replacement_top;
    import bpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    int   src_idle_pct = 27;
    int   snk_idle_pct = 81;
    int   items_sent = 0;
    int   errors, pending, rsp_count;
    int   quiet_cycles = 0;

    // a small working set of files and pages so that hits, pins and evictions recur
    logic [7:0]  file_set[4] = '{8'd1, 8'd2, 8'd200, 8'd255};
    logic [19:0] page_set[6] = '{20'd0, 20'd1, 20'd2, 20'd3, 20'hFFFFF, 20'h5A5A5};

    bpc_chan_if #(.T(req_item_t)) req_ch();
    bpc_chan_if #(.T(rsp_item_t)) rsp_ch();

    buffer_pool_clock_replacement_top DUT (
        .clk(clk), .rst_n(rst_n), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
    );

    bpc_frame_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_fire(req_ch.valid && req_ch.ready), .req_item(req_ch.data),
        .rsp_fire(rsp_ch.valid && rsp_ch.ready), .rsp_item(rsp_ch.data),
        .errors(errors), .pending(pending), .rsp_count(rsp_count)
    );

    always #2 clk = ~clk;

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
    end

    // receiver: stall at random at the current rate
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

    // watchdog: count cycles with no item moving on either channel
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("buffer_pool_clock_replacement_top: mismatch");
            $finish;
        end
    end

    // hold the item on the channel until it is accepted, idling beforehand at random
    task automatic send_req(input logic [2:0] rt, input logic [7:0] fl,
                            input logic [19:0] pg, input logic dirty);
        req_item_t it;
        it.req_type = rt; it.file_id = fl; it.page_no = pg; it.mark_dirty = dirty;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 0;
            @(posedge clk);
        end
        req_ch.valid <= 1;
        req_ch.data <= it;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        do @(posedge clk); while (pending != 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_req();
        int r;
        logic [2:0]  rt;
        logic [7:0]  fl;
        logic [19:0] pg;
        r = $urandom_range(99);
        // mostly reads and unpins on the working set, some alloc/dispose/flush and noise
        if (r < 40) rt = REQ_READ;
        else if (r < 70) rt = REQ_UNPIN;
        else if (r < 80) rt = REQ_ALLOC;
        else if (r < 88) rt = REQ_DISPOSE;
        else if (r < 95) rt = REQ_FLUSH;
        else rt = 3'($urandom_range(7));
        fl = ($urandom_range(9) == 0) ? 8'($urandom) : file_set[$urandom_range(3)];
        pg = ($urandom_range(9) == 0) ? 20'($urandom) : page_set[$urandom_range(5)];
        send_req(rt, fl, pg, 1'($urandom));
    endtask

    initial begin
        req_ch.valid = 0;
        req_ch.data = '0;
        @(posedge rst_n);
        @(posedge clk);
        // directed: extremes, every request type, special cases
        send_req(REQ_UNPIN, 8'd1, 20'd0, 1);          // unpin not resident
        send_req(REQ_READ, 8'd1, 20'd0, 0);           // miss with fill
        send_req(REQ_READ, 8'd1, 20'd0, 0);           // hit
        send_req(REQ_UNPIN, 8'd1, 20'd0, 1);
        send_req(REQ_UNPIN, 8'd1, 20'd0, 1);          // now dirty
        send_req(REQ_UNPIN, 8'd1, 20'd0, 0);          // not pinned
        send_req(REQ_ALLOC, 8'd255, 20'hFFFFF, 0);
        send_req(REQ_ALLOC, 8'd1, 20'd0, 0);          // already resident elsewhere
        send_req(REQ_DISPOSE, 8'd255, 20'hFFFFF, 0);  // pinned, freed anyway
        send_req(REQ_DISPOSE, 8'd7, 20'd9, 0);        // not resident
        send_req(REQ_READ, 8'd2, 20'd5, 0);
        send_req(REQ_FLUSH, 8'd2, 20'd0, 0);          // pinned frame stops the flush
        send_req(REQ_UNPIN, 8'd2, 20'd5, 1);
        send_req(REQ_FLUSH, 8'd2, 20'd0, 0);          // write-back then free
        send_req(3'd5, 8'd3, 20'd3, 0);               // unknown request types
        send_req(3'd7, 8'd0, 20'd0, 1);
        // fill every frame with pins, then one more read fails with buffer full
        for (int i = 0; i < 33; i++)
            send_req(REQ_READ, 8'd100, 20'(i), 0);
        drain();
        // pressure: wait for every expected result before releasing the pool
        for (int i = 0; i < 33; i++)
            send_req(REQ_UNPIN, 8'd100, 20'(i), 1'(i));
        send_req(REQ_FLUSH, 8'd100, 20'd0, 0);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 81 : 0;
            snk_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 27 : 0;
            for (int n = 0; n < 49; n++)
                random_req();
        end
        drain();

        $display("covered %0d requests and %0d result items over three idling phases",
                 items_sent, rsp_count);
        if (errors == 0)
            $display("buffer_pool_clock_replacement_top: match");
        else
            $display("buffer_pool_clock_replacement_top: mismatch");
        $finish;
    end
endmodule
